// ===== rtl/isort_pkg.sv =====
// shared constants and types for the insertion sorter
package isort_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_PLACE,
      ST_PRIME,
      ST_EMIT
   } isort_state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [31:0]       wdata;
      logic [ADDR_W-1:0] raddr;
   } isort_mem_req_type;

endpackage

// ===== rtl/insertion_sorter.sv =====
// insertion sorter top level: sequencer and sorted store
// Usage:
//   A request (req_value, req_batch_end) is taken at a rising edge where start
//   is high and busy is low. Each value is inserted into a sorted store of
//   isort_pkg::DEPTH entries, after any equal entries, by one comparator
//   walking down the store one entry per cycle through its single read port.
//   Inserting into an empty store writes the value directly to entry 0;
//   if the store is full the value is dropped and overflow is noted;
//   otherwise the walk's length is set by the number of entries shifted.
//   A request with req_batch_end high is followed, after its insertion, by
//   a prime state and then one result per stored value on consecutive
//   cycles, each marked by rsp_valid for one cycle: rsp_sorted_value in
//   ascending order, rsp_run_last on the final result, rsp_overflowed on all
//   results if a value of the batch was dropped. busy stays high throughout.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset (synchronous) empties the store count and the overflow flag; the
//   store itself needs no clearing pass.
module insertion_sorter (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic               req_batch_end,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_sorted_value,
   output logic               rsp_run_last,
   output logic               rsp_overflowed
);

   isort_pkg::isort_mem_req_type mem_req;
   logic [31:0]                  rdata;

   isort_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_batch_end    (req_batch_end),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_overflowed   (rsp_overflowed),
      .mem_req          (mem_req),
      .rdata            (rdata)
   );

   isort_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

endmodule

// ===== rtl/isort_store.sv =====
// sorted store: one write port and one registered read port
module isort_store (
   input  logic                          clock,
   input  isort_pkg::isort_mem_req_type  mem_req,
   output logic [31:0]                   rdata
);

   logic [31:0] mem_ff [isort_pkg::DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem_ff[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/isort_seq.sv =====
// sequencer with the single compare unit: insertion walk and output run
module isort_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_value,
   input  logic                          req_batch_end,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_sorted_value,
   output logic                          rsp_run_last,
   output logic                          rsp_overflowed,
   output isort_pkg::isort_mem_req_type  mem_req,
   input  logic [31:0]                   rdata
);

   localparam int AW = isort_pkg::ADDR_W;
   localparam int CW = isort_pkg::CNT_W;

   isort_pkg::isort_state_type state_ff, state_in;
   logic [31:0]   value_ff, value_in;
   logic          last_ff, last_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] k_ff, k_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          less;
   logic          run_last;
   logic [CW-1:0] count_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isort_pkg::ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      value_ff <= value_in;
      last_ff  <= last_in;
      pos_ff   <= pos_in;
      k_ff     <= k_in;
   end

   // the one comparator: new value against the entry read last cycle
   assign less     = $signed(value_ff) < $signed(rdata);
   assign count_m1 = count_ff - CW'(1);
   assign run_last = (CW'(k_ff) == count_m1);

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = pos_ff;
      mem_req.wdata = value_ff;
      mem_req.raddr = k_ff + AW'(1);
      rsp_valid     = 1'b0;
      unique case (state_ff)
         isort_pkg::ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               last_in  = req_batch_end;
               if (count_ff >= CW'(isort_pkg::DEPTH)) begin
                  // store full: drop the request
                  ovf_in   = 1'b1;
                  state_in = req_batch_end ? isort_pkg::ST_PRIME : isort_pkg::ST_IDLE;
               end else if (count_ff == '0) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = '0;
                  mem_req.wdata = req_value;
                  count_in      = CW'(1);
                  state_in = req_batch_end ? isort_pkg::ST_PRIME : isort_pkg::ST_IDLE;
               end else begin
                  pos_in        = AW'(count_ff);
                  mem_req.raddr = AW'(count_m1);
                  state_in      = isort_pkg::ST_CMP;
               end
            end
         end
         isort_pkg::ST_CMP: begin
            mem_req.we = 1'b1;
            if (less) begin
               // shift the entry up one place and look further down
               mem_req.wdata = rdata;
               pos_in        = pos_ff - AW'(1);
               mem_req.raddr = pos_ff - AW'(2);
               if (pos_ff == AW'(1)) begin
                  state_in = isort_pkg::ST_PLACE;
               end
            end else begin
               count_in = count_ff + CW'(1);
               state_in = last_ff ? isort_pkg::ST_PRIME : isort_pkg::ST_IDLE;
            end
         end
         isort_pkg::ST_PLACE: begin
            mem_req.we = 1'b1;
            count_in   = count_ff + CW'(1);
            state_in   = last_ff ? isort_pkg::ST_PRIME : isort_pkg::ST_IDLE;
         end
         isort_pkg::ST_PRIME: begin
            mem_req.raddr = '0;
            k_in          = '0;
            state_in      = isort_pkg::ST_EMIT;
         end
         isort_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            k_in      = k_ff + AW'(1);
            if (run_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = isort_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isort_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != isort_pkg::ST_IDLE);
   assign rsp_sorted_value = $signed(rdata);
   assign rsp_run_last     = run_last;
   assign rsp_overflowed   = ovf_ff;

`ifndef SYNTHESIS
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(isort_pkg::DEPTH))
      else $error("fill count beyond capacity");
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |=> !rsp_valid && count_ff == '0 && !ovf_ff)
      else $error("batch not cleared after final result");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && count_ff != '0 && count_ff < CW'(isort_pkg::DEPTH) |=> busy)
      else $error("insertion walk did not start");
`endif

endmodule

// ===== tb/tb_insertion_sorter.sv =====
// self-checking testbench for the insertion sorter: directed table, random batches
`timescale 1ns / 1ps

module tb_insertion_sorter;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int RANDOM_ITEMS   = 440;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 2 * isort_pkg::DEPTH + 8;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
      logic               overflowed;
   } sorted_item_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
      logic               typed;
      logic signed [31:0] want;
   } directed_row_type;

   // typed rows are single-value batches, so the run is just that value
   localparam directed_row_type DIRECTED [22] = '{
      '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
      '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
      '{32'sd0, 1'b1, 1'b1, 32'sd0},
      '{-32'sd1, 1'b1, 1'b1, -32'sd1},
      '{32'sd5, 1'b0, 1'b0, 32'sd0},
      '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
      '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
      '{-32'sd1, 1'b0, 1'b0, 32'sd0},
      '{32'sd0, 1'b0, 1'b0, 32'sd0},
      '{32'sd5, 1'b0, 1'b0, 32'sd0},
      '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
      '{-32'sd5, 1'b1, 1'b0, 32'sd0},
      '{32'sd3, 1'b0, 1'b0, 32'sd0},
      '{32'sd2, 1'b0, 1'b0, 32'sd0},
      '{32'sd1, 1'b0, 1'b0, 32'sd0},
      '{32'sd0, 1'b0, 1'b0, 32'sd0},
      '{-32'sd1, 1'b1, 1'b0, 32'sd0},
      '{-32'sd2, 1'b0, 1'b0, 32'sd0},
      '{32'sd7, 1'b0, 1'b0, 32'sd0},
      '{32'sd100, 1'b1, 1'b0, 32'sd0},
      '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
      '{32'shaaaa_aaaa, 1'b1, 1'b0, 32'sd0}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_value;
   logic               req_batch_end;
   logic               rsp_valid;
   logic signed [31:0] rsp_sorted_value;
   logic               rsp_run_last;
   logic               rsp_overflowed;

   // shadow copy of the sorter's state
   logic signed [31:0] shadow_store [isort_pkg::DEPTH];
   int                 shadow_fill;
   bit                 shadow_dropped;
   sorted_item_type    shadow_run [$];

   sorted_item_type    pending_sorted [$];
   int                 mismatch_count;
   int                 quiet_cycles;
   bit                 steady;

   insertion_sorter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_batch_end    (req_batch_end),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_overflowed   (rsp_overflowed)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // insert after equal entries; on batch end the whole store becomes the run
   task automatic shadow_insert(input logic signed [31:0] v, input bit last);
      int pos;
      shadow_run.delete();
      if (shadow_fill >= isort_pkg::DEPTH) begin
         shadow_dropped = 1'b1;
      end else begin
         pos = shadow_fill;
         while (pos > 0 && v < shadow_store[pos-1]) begin
            shadow_store[pos] = shadow_store[pos-1];
            pos--;
         end
         shadow_store[pos] = v;
         shadow_fill++;
      end
      if (last) begin
         for (int k = 0; k < shadow_fill; k++)
            shadow_run.push_back('{shadow_store[k], k == shadow_fill - 1, shadow_dropped});
         shadow_fill    = 0;
         shadow_dropped = 1'b0;
      end
   endtask

   // drive one request, wait for it to be taken, then queue what it should produce
   task automatic issue_value(input logic signed [31:0] v, input bit last,
                              input bit typed, input logic signed [31:0] want);
      if (!steady && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start         <= 1'b1;
      req_value     <= v;
      req_batch_end <= last;
      do @(posedge clock); while (busy);
      shadow_insert(v, last);
      if (typed && last)
         pending_sorted.push_back('{want, 1'b1, 1'b0});
      else
         foreach (shadow_run[k]) pending_sorted.push_back(shadow_run[k]);
   endtask

   task automatic flag_mismatch(input string what, input sorted_item_type want,
                                input sorted_item_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected value %0d last %0b ovf %0b, %s %0d last %0b ovf %0b",
                  $realtime, what, want.value, want.last, want.overflowed,
                  "got value", got.value, got.last, got.overflowed);
   endtask

   always @(posedge clock) begin : result_check
      sorted_item_type got;
      sorted_item_type want;
      if (!reset) begin
         got = '{rsp_sorted_value, rsp_run_last, rsp_overflowed};
         if (rsp_valid) begin
            if (pending_sorted.size() == 0) begin
               flag_mismatch("unexpected result", '0, got);
            end else begin
               want = pending_sorted.pop_front();
               if (got.value !== want.value || got.last !== want.last ||
                   got.overflowed !== want.overflowed)
                  flag_mismatch("result mismatch", want, got);
            end
         end
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int                 batch_len;
      int                 sent;
      logic signed [31:0] v;
      mismatch_count = 0;
      quiet_cycles   = 0;
      shadow_fill    = 0;
      shadow_dropped = 1'b0;
      steady         = 1'b0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_value     <= '0;
      req_batch_end <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++)
         issue_value(DIRECTED[r].value, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // one batch in five reaches the depth and most of those overflow; one over depth drops the final value
         case ($urandom_range(0, 9))
            0:       batch_len = isort_pkg::DEPTH + 1;
            1:       batch_len = $urandom_range(isort_pkg::DEPTH, isort_pkg::DEPTH + 4);
            2:       batch_len = 1;
            default: batch_len = $urandom_range(2, isort_pkg::DEPTH - 1);
         endcase
         for (int i = 0; i < batch_len; i++) begin
            case ($urandom_range(0, 9)) inside
               [0:4]:   v = $urandom;
               [5:7]:   v = $signed($urandom_range(0, 8)) - 4;
               8:       v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
               default: v = -$signed($urandom_range(1, 1000));
            endcase
            // a stretch of back-to-back requests
            steady = (sent >= 150 && sent < 260);
            issue_value(v, i == batch_len - 1, 1'b0, '0);
            sent++;
         end
      end
      start <= 1'b0;

      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_sorted.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/isort_pkg.sv
rtl/isort_store.sv
rtl/isort_seq.sv
rtl/insertion_sorter.sv
tb/tb_insertion_sorter.sv
